// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; the enclosing module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HFF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hff_pkg.sv =====
package hff_pkg;

    localparam int unsigned DBZ_W     = 16;
    localparam int unsigned COEF_W    = 24;
    localparam int unsigned INV_W     = 20;
    localparam int unsigned FLUX_W    = 32;
    localparam int unsigned MANT_W    = 31;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_THR,
        REG_UPPER_THR,
        REG_MISSING,
        REG_BAD,
        REG_MASS_LOG,
        REG_MASS_INV,
        REG_KE_LOG,
        REG_KE_INV
    } cfg_reg_t;

    // dbz*256 + 5, biased so the dividend stays positive
    localparam logic [27:0] DIV_OFFSET   = 28'd167772165;
    // ceil(2^31 / 10); exact floor division for dividends below 2^30
    localparam logic [27:0] RECIP_TEN    = 28'd214748365;
    localparam logic [24:0] D_BIAS       = 25'd16777216;
    // log2(10) in Q24
    localparam logic [25:0] LOG2_TEN_Q24 = 26'd55732705;
    localparam logic [FLUX_W-1:0] FLUX_MAX = 32'hFFFF_FFFF;

    localparam logic signed [DBZ_W-1:0] MISSING_RST = 16'sh8000;
    localparam logic signed [DBZ_W-1:0] BAD_RST     = 16'sh8001;
    localparam logic [INV_W-1:0]        INV_RST     = 20'd65536;

    typedef struct packed {
        logic               ok;
        logic signed [20:0] d;
    } s0_t;

    typedef struct packed {
        logic               ok;
        logic signed [24:0] t_m;
        logic signed [24:0] t_e;
    } s1_t;

    typedef struct packed {
        logic               ok;
        logic signed [28:0] e_m;
        logic signed [28:0] e_e;
    } s2_t;

    typedef struct packed {
        logic               ok;
        logic signed [30:0] y_m;
        logic signed [30:0] y_e;
    } s3_t;

    typedef struct packed {
        logic               ok;
        logic signed [14:0] ip_m;
        logic signed [14:0] ip_e;
        logic [MANT_W-1:0]  m_m;
        logic [MANT_W-1:0]  m_e;
    } s4_t;

    typedef struct packed {
        logic              ok;
        logic [FLUX_W-1:0] mass;
        logic [FLUX_W-1:0] energy;
        logic              sat;
    } s5_t;

    typedef struct packed {
        logic              sat;
        logic [FLUX_W-1:0] val;
    } flux_t;

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned rem;
        longint unsigned r;
        longint unsigned step;
        rem  = v;
        r    = 64'd0;
        step = 64'h4000_0000_0000_0000;
        while (step > rem)
            step = step >> 2;
        while (step != 64'd0)
        begin
            if (rem >= r + step)
            begin
                rem = rem - (r + step);
                r   = (r >> 1) + step;
            end
            else
            begin
                r = r >> 1;
            end
            step = step >> 2;
        end
        return r;
    endfunction

    // 2^(k / 2^addr_bits) in Q30, built from successive square roots of 2
    function automatic logic [MANT_W-1:0] exp_entry(int unsigned addr_bits, int unsigned k);
        longint unsigned root;
        longint unsigned m;
        int unsigned     j;
        root = 64'd2 << 30;
        m    = 64'd1 << 30;
        for (j = 1; j <= addr_bits; j++)
        begin
            root = isqrt64(root << 30);
            if (((k >> (addr_bits - j)) & 1) != 0)
                m = (m * root + (64'd1 << 29)) >> 30;
        end
        return m[MANT_W-1:0];
    endfunction

    // Scale the Q30 mantissa by 2^(ip-14), rounding half up, saturating.
    function automatic flux_t flux_shift(logic signed [14:0] ip, logic [MANT_W-1:0] m);
        flux_t       r;
        logic [4:0]  sh;
        logic [32:0] acc;
        r.sat = 1'b0;
        r.val = '0;
        sh    = '0;
        acc   = '0;
        priority if (ip >= 15'sd16)
        begin
            r.sat = 1'b1;
            r.val = FLUX_MAX;
        end
        else if (ip < -15'sd17)
        begin
            r.val = '0;
        end
        else if (ip >= 15'sd14)
        begin
            sh    = 5'(ip - 15'sd14);
            acc   = {2'b00, m} << sh;
            r.val = acc[FLUX_W-1:0];
        end
        else
        begin
            sh    = 5'(15'sd14 - ip);
            acc   = ({2'b00, m} + (33'd1 << (sh - 5'd1))) >> sh;
            r.val = acc[FLUX_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/hff_cell.sv =====
module hff_cell
    import hff_pkg::*;
#(
    parameter int unsigned WIDTH = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  logic [WIDTH-1:0] up_data,
    output logic             dn_valid,
    input  logic             dn_ready,
    output logic [WIDTH-1:0] dn_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;

    // take a new request when empty or when the neighbor drains us
    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= up_data;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== hw/rtl/hff_exp_tab.sv =====
module hff_exp_tab
    import hff_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 8
)
(
    input  logic [ADDR_BITS-1:0] addr,
    output logic [MANT_W-1:0]    data
);

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    logic [MANT_W-1:0] rom [DEPTH];

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_rom
        localparam logic [MANT_W-1:0] ENTRY = exp_entry(ADDR_BITS, k);
        assign rom[k] = ENTRY;
    end

    assign data = rom[addr];

endmodule

// ===== hw/rtl/hail_flux_from_reflectivity.sv =====
// Channel  | Direction | Signals                            | Transfer on
// ---------+-----------+------------------------------------+-----------------------
// cell     | in        | upper_dbz, lower_dbz               | cell_valid & cell_ready
// flux     | out       | valid_res, mass_flux, energy_flux, | flux_valid & flux_ready
//          |           | saturated                          |
// cfg      | in        | cfg_index, cfg_data                | cfg_valid & cfg_ready
//
// One request per clock sustained while flux_ready stays high; each taken request is
// registered in every cell of the six-cell chain in turn on its way to the output.
// The chain cells are divide-by-ten, subtract, scale, log2 scale, table lookup, shift.
// Reset clears the valid bit of every cell and loads the register defaults; the
// exponent table is constant and needs no fill.
// A stall on flux_ready holds only the full cells; empty cells downstream of the
// input keep taking requests until the chain is full.
`include "assert_macros.svh"

module hail_flux_from_reflectivity
    import hff_pkg::*;
#(
    parameter int unsigned EXP_TABLE_ADDR_BITS = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cell_valid,
    output logic                     cell_ready,
    input  logic signed [DBZ_W-1:0]  upper_dbz,
    input  logic signed [DBZ_W-1:0]  lower_dbz,

    output logic                     flux_valid,
    input  logic                     flux_ready,
    output logic                     valid_res,
    output logic [FLUX_W-1:0]        mass_flux,
    output logic [FLUX_W-1:0]        energy_flux,
    output logic                     saturated,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DAT_W-1:0]     cfg_data
);

    logic signed [DBZ_W-1:0]  lower_thr_reg;
    logic signed [DBZ_W-1:0]  upper_thr_reg;
    logic signed [DBZ_W-1:0]  missing_reg;
    logic signed [DBZ_W-1:0]  bad_reg;
    logic signed [COEF_W-1:0] mass_log_reg;
    logic [INV_W-1:0]         mass_inv_reg;
    logic signed [COEF_W-1:0] ke_log_reg;
    logic [INV_W-1:0]         ke_inv_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_thr_reg <= '0;
            upper_thr_reg <= '0;
            missing_reg   <= MISSING_RST;
            bad_reg       <= BAD_RST;
            mass_log_reg  <= '0;
            mass_inv_reg  <= INV_RST;
            ke_log_reg    <= '0;
            ke_inv_reg    <= INV_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOWER_THR: lower_thr_reg <= cfg_data[DBZ_W-1:0];
                REG_UPPER_THR: upper_thr_reg <= cfg_data[DBZ_W-1:0];
                REG_MISSING:   missing_reg   <= cfg_data[DBZ_W-1:0];
                REG_BAD:       bad_reg       <= cfg_data[DBZ_W-1:0];
                REG_MASS_LOG:  mass_log_reg  <= cfg_data[COEF_W-1:0];
                REG_MASS_INV:  mass_inv_reg  <= cfg_data[INV_W-1:0];
                REG_KE_LOG:    ke_log_reg    <= cfg_data[COEF_W-1:0];
                REG_KE_INV:    ke_inv_reg    <= cfg_data[INV_W-1:0];
            endcase
        end
    end

    logic v0, v1, v2, v3, v4;
    logic r0, r1, r2, r3, r4, r5;
    s0_t  s0_next, s0_q;
    s1_t  s1_next, s1_q;
    s2_t  s2_next, s2_q;
    s3_t  s3_next, s3_q;
    s4_t  s4_next, s4_q;
    s5_t  s5_next, s5_q;

    // Cell 0: screen the samples and divide by ten through the reciprocal
    logic        upper_bad;
    logic        lower_bad;
    logic [27:0] div_num;
    logic [55:0] div_prod;
    logic [24:0] div_quo;

    always_comb
    begin
        upper_bad  = (upper_dbz == missing_reg) || (upper_dbz == bad_reg) ||
                     (upper_dbz < upper_thr_reg);
        lower_bad  = (lower_dbz == missing_reg) || (lower_dbz == bad_reg) ||
                     (lower_dbz < lower_thr_reg);
        div_num    = {{4{lower_dbz[DBZ_W-1]}}, lower_dbz, 8'h00} + DIV_OFFSET;
        div_prod   = {28'd0, div_num} * {28'd0, RECIP_TEN};
        div_quo    = div_prod[55:31];
        s0_next.ok = !(upper_bad || lower_bad);
        s0_next.d  = 21'(div_quo - D_BIAS);
    end

    // Cell 1: remove log10 of each coefficient
    always_comb
    begin
        s1_next.ok  = s0_q.ok;
        s1_next.t_m = {{4{s0_q.d[20]}}, s0_q.d} - {mass_log_reg[COEF_W-1], mass_log_reg};
        s1_next.t_e = {{4{s0_q.d[20]}}, s0_q.d} - {ke_log_reg[COEF_W-1], ke_log_reg};
    end

    // Cell 2: scale by the reciprocal exponents
    logic signed [45:0] inv_prod_m;
    logic signed [45:0] inv_prod_e;

    always_comb
    begin
        inv_prod_m  = s1_q.t_m * $signed({1'b0, mass_inv_reg});
        inv_prod_e  = s1_q.t_e * $signed({1'b0, ke_inv_reg});
        s2_next.ok  = s1_q.ok;
        s2_next.e_m = inv_prod_m[44:16];
        s2_next.e_e = inv_prod_e[44:16];
    end

    // Cell 3: convert the decimal exponent to base 2
    logic signed [55:0] l2_prod_m;
    logic signed [55:0] l2_prod_e;

    always_comb
    begin
        l2_prod_m   = s2_q.e_m * $signed({1'b0, LOG2_TEN_Q24});
        l2_prod_e   = s2_q.e_e * $signed({1'b0, LOG2_TEN_Q24});
        s3_next.ok  = s2_q.ok;
        s3_next.y_m = l2_prod_m[54:24];
        s3_next.y_e = l2_prod_e[54:24];
    end

    // Cell 4: split integer and fraction, look up the mantissa
    logic [MANT_W-1:0] mant_m;
    logic [MANT_W-1:0] mant_e;

    hff_exp_tab #(
        .ADDR_BITS (EXP_TABLE_ADDR_BITS)
    ) u_tab_m (
        .addr (s3_q.y_m[15 -: EXP_TABLE_ADDR_BITS]),
        .data (mant_m)
    );

    hff_exp_tab #(
        .ADDR_BITS (EXP_TABLE_ADDR_BITS)
    ) u_tab_e (
        .addr (s3_q.y_e[15 -: EXP_TABLE_ADDR_BITS]),
        .data (mant_e)
    );

    always_comb
    begin
        s4_next.ok   = s3_q.ok;
        s4_next.ip_m = s3_q.y_m[30:16];
        s4_next.ip_e = s3_q.y_e[30:16];
        s4_next.m_m  = mant_m;
        s4_next.m_e  = mant_e;
    end

    // Cell 5: shift into Q16.16, zero out undefined cells
    flux_t fm;
    flux_t fe;

    always_comb
    begin
        fm             = flux_shift(s4_q.ip_m, s4_q.m_m);
        fe             = flux_shift(s4_q.ip_e, s4_q.m_e);
        s5_next.ok     = s4_q.ok;
        s5_next.mass   = s4_q.ok ? fm.val : '0;
        s5_next.energy = s4_q.ok ? fe.val : '0;
        s5_next.sat    = s4_q.ok && (fm.sat || fe.sat);
    end

    hff_cell #(.WIDTH($bits(s0_t))) u_c0 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (cell_valid), .up_ready (r0), .up_data (s0_next),
        .dn_valid (v0), .dn_ready (r1), .dn_data (s0_q)
    );

    hff_cell #(.WIDTH($bits(s1_t))) u_c1 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (v0), .up_ready (r1), .up_data (s1_next),
        .dn_valid (v1), .dn_ready (r2), .dn_data (s1_q)
    );

    hff_cell #(.WIDTH($bits(s2_t))) u_c2 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (v1), .up_ready (r2), .up_data (s2_next),
        .dn_valid (v2), .dn_ready (r3), .dn_data (s2_q)
    );

    hff_cell #(.WIDTH($bits(s3_t))) u_c3 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (v2), .up_ready (r3), .up_data (s3_next),
        .dn_valid (v3), .dn_ready (r4), .dn_data (s3_q)
    );

    hff_cell #(.WIDTH($bits(s4_t))) u_c4 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (v3), .up_ready (r4), .up_data (s4_next),
        .dn_valid (v4), .dn_ready (r5), .dn_data (s4_q)
    );

    hff_cell #(.WIDTH($bits(s5_t))) u_c5 (
        .clk (clk), .rst_n (rst_n),
        .up_valid (v4), .up_ready (r5), .up_data (s5_next),
        .dn_valid (flux_valid), .dn_ready (flux_ready), .dn_data (s5_q)
    );

    assign cell_ready  = r0;
    assign valid_res   = s5_q.ok;
    assign mass_flux   = s5_q.mass;
    assign energy_flux = s5_q.energy;
    assign saturated   = s5_q.sat;

    `HFF_ASSERT_IMPL(a_undef_zero, flux_valid && !valid_res,
        mass_flux == '0 && energy_flux == '0 && !saturated,
        "undefined cell carries nonzero flux")
    `HFF_ASSERT_IMPL(a_sat_max, flux_valid && saturated,
        mass_flux == FLUX_MAX || energy_flux == FLUX_MAX,
        "saturation flagged without a clipped flux")
    `HFF_ASSERT_IMPL(a_full_only_on_stall, !cell_ready,
        flux_valid && !flux_ready,
        "chain refuses a request while the output drains")
    `HFF_ASSERT_NEXT(a_last_hop, v4 && r5,
        flux_valid && (valid_res == $past(s4_q.ok)),
        "result lost between lookup cell and output")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
    import hff_pkg::*;
();

    localparam int TBL_BITS = 8;
    localparam longint LOG2_10_Q24 = 64'sd55732705;

    typedef struct packed {
        logic        ok;
        logic [31:0] mass;
        logic [31:0] energy;
        logic        sat;
    } flux_expect_t;

    class FluxScoreboard;
        longint lower_thr;
        longint upper_thr;
        longint miss_code;
        longint bad_code;
        longint mass_log;
        longint mass_inv;
        longint ke_log;
        longint ke_inv;
        longint unsigned pow2_frac [2**TBL_BITS];
        flux_expect_t pending_q [$];
        int errors;

        function new();
            longint unsigned roots [1:TBL_BITS];
            longint unsigned prev;
            longint unsigned m;
            int j;
            int k;
            prev = 64'd2 << 30;
            for (j = 1; j <= TBL_BITS; j++)
            begin
                prev = int_root(prev << 30);
                roots[j] = prev;
            end
            for (k = 0; k < 2**TBL_BITS; k++)
            begin
                m = 64'd1 << 30;
                for (j = 1; j <= TBL_BITS; j++)
                    if (((k >> (TBL_BITS - j)) & 1) != 0)
                        m = (m * roots[j] + (64'd1 << 29)) >> 30;
                pow2_frac[k] = m;
            end
            lower_thr = 0;
            upper_thr = 0;
            miss_code = -32768;
            bad_code  = -32767;
            mass_log  = 0;
            mass_inv  = 65536;
            ke_log    = 0;
            ke_inv    = 65536;
            errors    = 0;
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned r;
            longint unsigned cand;
            int b;
            r = 0;
            for (b = 31; b >= 0; b--)
            begin
                cand = r | (64'd1 << b);
                if (cand * cand <= v)
                    r = cand;
            end
            return r;
        endfunction

        function void set_reg(cfg_reg_t r, bit [23:0] v);
            case (r)
                REG_LOWER_THR: lower_thr = longint'($signed(v[15:0]));
                REG_UPPER_THR: upper_thr = longint'($signed(v[15:0]));
                REG_MISSING:   miss_code = longint'($signed(v[15:0]));
                REG_BAD:       bad_code  = longint'($signed(v[15:0]));
                REG_MASS_LOG:  mass_log  = longint'($signed(v));
                REG_MASS_INV:  mass_inv  = longint'(v[19:0]);
                REG_KE_LOG:    ke_log    = longint'($signed(v));
                REG_KE_INV:    ke_inv    = longint'(v[19:0]);
                default: ;
            endcase
        endfunction

        // 10^((dbz/10 - log a) / b) as a base-2 power via the fraction table
        function bit [31:0] law_flux(longint dbz, longint log_coef, longint inv_exp,
                                     output bit clipped);
            longint d;
            longint t;
            longint e;
            longint y;
            longint ip;
            longint s;
            longint unsigned m;
            int idx;
            clipped = 1'b0;
            d   = (dbz * 256 + 167772165) / 10 - 16777216;
            t   = d - log_coef;
            e   = (t * inv_exp) >>> 16;
            y   = (e * LOG2_10_Q24) >>> 24;
            ip  = y >>> 16;
            idx = int'((y - (ip <<< 16)) >>> (16 - TBL_BITS));
            m   = pow2_frac[idx];
            if (ip >= 16)
            begin
                clipped = 1'b1;
                return 32'hFFFF_FFFF;
            end
            if (ip < -17)
                return 32'd0;
            if (ip >= 14)
                return 32'(m << (ip - 14));
            s = 14 - ip;
            return 32'((m + (64'd1 << (s - 1))) >> s);
        endfunction

        function void note_cell(logic signed [15:0] up, logic signed [15:0] lo);
            flux_expect_t x;
            longint u;
            longint l;
            bit c_mass;
            bit c_ke;
            u = up;
            l = lo;
            x = '0;
            if (!(u == miss_code || u == bad_code || u < upper_thr ||
                  l == miss_code || l == bad_code || l < lower_thr))
            begin
                x.ok     = 1'b1;
                x.mass   = law_flux(l, mass_log, mass_inv, c_mass);
                x.energy = law_flux(l, ke_log, ke_inv, c_ke);
                x.sat    = c_mass | c_ke;
            end
            pending_q.push_back(x);
        endfunction

        function void check_flux(logic ok, logic [31:0] mass, logic [31:0] energy,
                                 logic sat);
            flux_expect_t x;
            if (pending_q.size() == 0)
            begin
                $error("flux result with no request pending");
                errors++;
                return;
            end
            x = pending_q.pop_front();
            if (ok !== x.ok)
            begin
                $error("valid_res: expected %0d, actual %0d", x.ok, ok);
                errors++;
            end
            if (mass !== x.mass)
            begin
                $error("mass_flux: expected %0h, actual %0h", x.mass, mass);
                errors++;
            end
            if (energy !== x.energy)
            begin
                $error("energy_flux: expected %0h, actual %0h", x.energy, energy);
                errors++;
            end
            if (sat !== x.sat)
            begin
                $error("saturated: expected %0d, actual %0d", x.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cell_valid;
    logic                    cell_ready;
    logic signed [DBZ_W-1:0] upper_dbz;
    logic signed [DBZ_W-1:0] lower_dbz;
    logic                    flux_valid;
    logic                    flux_ready;
    logic                    valid_res;
    logic [FLUX_W-1:0]       mass_flux;
    logic [FLUX_W-1:0]       energy_flux;
    logic                    saturated;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DAT_W-1:0]    cfg_data;

    FluxScoreboard sb;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  long_stall_req;
    bit  long_stall_done;
    int  stall_left;

    hail_flux_from_reflectivity #(
        .EXP_TABLE_ADDR_BITS(TBL_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cell_valid  (cell_valid),
        .cell_ready  (cell_ready),
        .upper_dbz   (upper_dbz),
        .lower_dbz   (lower_dbz),
        .flux_valid  (flux_valid),
        .flux_ready  (flux_ready),
        .valid_res   (valid_res),
        .mass_flux   (mass_flux),
        .energy_flux (energy_flux),
        .saturated   (saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stalls, or one long hold-off when asked
    always @(negedge clk)
    begin
        if (long_stall_req && !long_stall_done)
        begin
            stall_left      = 80;
            long_stall_done = 1'b1;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            flux_ready <= 1'b0;
        end
        else
        begin
            flux_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && flux_valid && flux_ready)
            sb.check_flux(valid_res, mass_flux, energy_flux, saturated);
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_cell(logic signed [15:0] up, logic signed [15:0] lo);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cell_valid <= 1'b0;
            @(negedge clk);
        end
        cell_valid <= 1'b1;
        upper_dbz  <= up;
        lower_dbz  <= lo;
        do
            @(posedge clk);
        while (!cell_ready);
        sb.note_cell(up, lo);
        @(negedge clk);
    endtask

    task automatic drain_flux();
        cell_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // write all eight registers; noise goes into the unused bits above each narrower register
    task automatic apply_setting(bit [23:0] vals [8]);
        bit [23:0] d;
        cfg_reg_t  r;
        for (int i = 0; i < 8; i++)
        begin
            r = cfg_reg_t'(i);
            d = vals[i];
            if (r == REG_LOWER_THR || r == REG_UPPER_THR || r == REG_MISSING || r == REG_BAD)
                d[23:16] = 8'($urandom);
            else if (r == REG_MASS_INV || r == REG_KE_INV)
                d[23:20] = 4'($urandom);
            cfg_valid <= 1'b1;
            cfg_index <= r;
            cfg_data  <= d;
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_reg(r, d);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // mostly in-range values above the threshold, some codes, edges and noise
    function automatic logic [15:0] pick_dbz(longint thr, longint miss, longint bad);
        int r;
        longint hi;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 16'(miss);
        if (r < 11)
            return 16'(bad);
        if (r < 25)
            return 16'($urandom);
        if (r < 32)
            return 16'(thr - 1 + longint'($urandom_range(0, 1)));
        hi = (thr + 17920 > 32767) ? 32767 : thr + 17920;
        return 16'(thr + longint'($urandom_range(0, int'(hi - thr))));
    endfunction

    initial
    begin
        bit [23:0] vals [8];
        int r;
        sb             = new();
        rst_n          = 1'b0;
        cell_valid     = 1'b0;
        upper_dbz      = '0;
        lower_dbz      = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_LOWER_THR;
        cfg_data       = '0;
        tx_idle_pct    = 34;
        rx_idle_pct    = 61;
        long_stall_req = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: codes, thresholds, unit flux, saturation boundary
        send_cell(16'sd0, 16'sd0);
        send_cell(16'sd32767, 16'sd32767);
        send_cell(-16'sd32768, 16'sd100);
        send_cell(-16'sd32767, 16'sd100);
        send_cell(16'sd100, -16'sd32768);
        send_cell(16'sd100, -16'sd32767);
        send_cell(-16'sd1, 16'sd100);
        send_cell(16'sd100, -16'sd1);
        send_cell(-16'sd32768, -16'sd32767);
        send_cell(16'sd0, 16'sd12329);
        send_cell(16'sd0, 16'sd12330);
        send_cell(16'sd0, 16'sd12331);
        send_cell(16'sd0, 16'sd2560);
        drain_flux();

        // lowest thresholds, moved codes, zero and largest reciprocal exponent
        vals[REG_LOWER_THR] = 24'(-32768);
        vals[REG_UPPER_THR] = 24'(-32768);
        vals[REG_MISSING]   = 24'(32767);
        vals[REG_BAD]       = 24'(32766);
        vals[REG_MASS_LOG]  = 24'd0;
        vals[REG_MASS_INV]  = 24'd0;
        vals[REG_KE_LOG]    = 24'd0;
        vals[REG_KE_INV]    = 24'd1048575;
        apply_setting(vals);
        send_cell(-16'sd32768, -16'sd32768);
        send_cell(16'sd0, -16'sd1280);
        send_cell(16'sd0, 16'sd0);
        send_cell(16'sd32767, 16'sd0);
        send_cell(16'sd0, 16'sd32766);
        send_cell(16'sd32765, 16'sd32765);
        send_cell(16'sd0, -16'sd5000);
        drain_flux();

        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                tx_idle_pct = 34;
                rx_idle_pct = 61;
            end
            else if (p < 4)
            begin
                tx_idle_pct = 61;
                rx_idle_pct = 34;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            vals[REG_LOWER_THR] = 24'(int'($urandom_range(0, 7680)) - 2560);
            vals[REG_UPPER_THR] = 24'(int'($urandom_range(0, 7680)) - 2560);
            if ($urandom_range(0, 1) == 0)
            begin
                vals[REG_MISSING] = 24'(-32768);
                vals[REG_BAD]     = 24'(-32767);
            end
            else
            begin
                vals[REG_MISSING] = 24'($urandom);
                vals[REG_BAD]     = 24'($urandom);
            end
            vals[REG_MASS_LOG] = 24'(int'($urandom_range(0, 393216)) - 196608);
            vals[REG_KE_LOG]   = 24'(int'($urandom_range(0, 393216)) - 196608);
            for (int k = 0; k < 2; k++)
            begin
                r = $urandom_range(0, 9);
                vals[k ? REG_KE_INV : REG_MASS_INV] =
                    (r == 0) ? 24'd0 :
                    (r == 1) ? 24'd1048575 : 24'($urandom_range(8192, 196608));
            end
            // extreme coefficients: in every defined cell mass clips and energy underflows
            if (p == 2)
            begin
                vals[REG_LOWER_THR] = 24'(-32768);
                vals[REG_UPPER_THR] = 24'(32767);
                vals[REG_MISSING]   = 24'd0;
                vals[REG_BAD]       = 24'd1;
                vals[REG_MASS_LOG]  = 24'h80_0000;
                vals[REG_MASS_INV]  = 24'd1048575;
                vals[REG_KE_LOG]    = 24'h7F_FFFF;
                vals[REG_KE_INV]    = 24'd1048575;
            end
            apply_setting(vals);
            if (p == 4)
                long_stall_req = 1'b1;
            for (int n = 0; n < 160; n++)
                send_cell(pick_dbz(sb.upper_thr, sb.miss_code, sb.bad_code),
                          pick_dbz(sb.lower_thr, sb.miss_code, sb.bad_code));
            drain_flux();
        end

        repeat (12) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/hff_pkg.sv
hw/rtl/hff_cell.sv
hw/rtl/hff_exp_tab.sv
hw/rtl/hail_flux_from_reflectivity.sv
bench/tb_top.sv
